>>> sv/exyz_pkg.sv
// ----------------------------------------------------------------------------
// exyz_pkg: shared types, constants and helpers for the XYZ rotation block
// Holds the CORDIC arctangent table, fixed-point formats and rounding helpers.
// ----------------------------------------------------------------------------
package exyz_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int OUT_BITS       = 16;
    localparam int CORDIC_STEPS   = 30;
    localparam int CORDIC_FRAC    = 30;
    localparam int CW             = 33;   // CORDIC x/y width
    localparam int ZW             = 33;   // CORDIC residual angle width
    localparam int CF             = COEF_FRAC_BITS + 2; // coefficient width
    localparam int PW             = 2 * CF;             // product width
    localparam int QDEPTH         = 4;
    localparam int QAW            = 2;

    localparam logic signed [CW-1:0] GAIN_INIT = CW'(652032874);
    localparam logic signed [CF-1:0] ONE_C     = CF'(1 << COEF_FRAC_BITS);

    typedef logic signed [CF-1:0] t_coef;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] ax;
        logic [ANGLE_BITS-1:0] ay;
        logic [ANGLE_BITS-1:0] az;
    } t_angles;

    typedef struct packed {
        t_coef sx; t_coef cx;
        t_coef sy; t_coef cy;
        t_coef sz; t_coef cz;
    } t_trig;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0:  atan_lut = ZW'(536870912);
            5'd1:  atan_lut = ZW'(316933406);
            5'd2:  atan_lut = ZW'(167458907);
            5'd3:  atan_lut = ZW'(85004756);
            5'd4:  atan_lut = ZW'(42667331);
            5'd5:  atan_lut = ZW'(21354465);
            5'd6:  atan_lut = ZW'(10679838);
            5'd7:  atan_lut = ZW'(5340245);
            5'd8:  atan_lut = ZW'(2670163);
            5'd9:  atan_lut = ZW'(1335087);
            5'd10: atan_lut = ZW'(667544);
            5'd11: atan_lut = ZW'(333772);
            5'd12: atan_lut = ZW'(166886);
            5'd13: atan_lut = ZW'(83443);
            5'd14: atan_lut = ZW'(41722);
            5'd15: atan_lut = ZW'(20861);
            5'd16: atan_lut = ZW'(10430);
            5'd17: atan_lut = ZW'(5215);
            5'd18: atan_lut = ZW'(2608);
            5'd19: atan_lut = ZW'(1304);
            5'd20: atan_lut = ZW'(652);
            5'd21: atan_lut = ZW'(326);
            5'd22: atan_lut = ZW'(163);
            5'd23: atan_lut = ZW'(81);
            5'd24: atan_lut = ZW'(41);
            5'd25: atan_lut = ZW'(20);
            5'd26: atan_lut = ZW'(10);
            5'd27: atan_lut = ZW'(5);
            5'd28: atan_lut = ZW'(3);
            5'd29: atan_lut = ZW'(1);
            default: atan_lut = '0;
        endcase
    endfunction

    // Round a product with 2F fraction bits to F, then clamp to +-1.0
    function automatic t_coef round_prod(input logic signed [PW:0] p);
        logic signed [PW:0] r;
        begin
            r = (p + (PW+1)'(1 << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (r > (PW+1)'(1 << COEF_FRAC_BITS))
                round_prod = ONE_C;
            else if (r < -(PW+1)'(1 << COEF_FRAC_BITS))
                round_prod = -ONE_C;
            else
                round_prod = r[CF-1:0];
        end
    endfunction

endpackage

>>> sv/exyz_cordic.sv
// ----------------------------------------------------------------------------
// exyz_cordic: pipelined CORDIC sine/cosine, one stage per iteration
// Folds the angle into the right half plane, rotates 30 steps, rounds to Q1.14.
// ----------------------------------------------------------------------------
module exyz_cordic
    import exyz_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output t_coef                 o_sin,
    output t_coef                 o_cos
);

    logic signed [CW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS+1];
    logic                 r_neg [CORDIC_STEPS+1];
    logic [31:0]          phase;
    logic [31:0]          fold;
    logic signed [CW-1:0] n_c;
    logic signed [CW-1:0] n_s;
    t_coef                r_sin;
    t_coef                r_cos;

    // Fold the phase so the residual is within a quarter turn
    always_comb begin
        phase = {i_angle, {(32-ANGLE_BITS){1'b0}}};
        fold  = (phase[31:30] == 2'b01 || phase[31:30] == 2'b10)
              ? phase - 32'h8000_0000 : phase;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= GAIN_INIT;
            r_y[0]   <= '0;
            r_z[0]   <= ZW'(signed'(fold));
            r_neg[0] <= (phase[31:30] == 2'b01 || phase[31:30] == 2'b10);
        end
    end

    // Advance one micro-rotation per stage
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][ZW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_lut(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_lut(5'(g));
                end
                r_neg[g+1] <= r_neg[g];
            end
        end
    end

    // Negate, round to coefficient precision and clamp
    always_comb begin
        n_c = r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        n_s = r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        n_c = (n_c + CW'(1 << (CORDIC_FRAC-1-COEF_FRAC_BITS)))
              >>> (CORDIC_FRAC - COEF_FRAC_BITS);
        n_s = (n_s + CW'(1 << (CORDIC_FRAC-1-COEF_FRAC_BITS)))
              >>> (CORDIC_FRAC - COEF_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= (n_c > CW'(ONE_C)) ? ONE_C : (n_c < -CW'(ONE_C)) ? -ONE_C
                   : n_c[CF-1:0];
            r_sin <= (n_s > CW'(ONE_C)) ? ONE_C : (n_s < -CW'(ONE_C)) ? -ONE_C
                   : n_s[CF-1:0];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

>>> sv/exyz_front.sv
// ----------------------------------------------------------------------------
// exyz_front: angle front end
// Accepts angle beats and runs three CORDIC pipes; pushes sin/cos into a queue.
// ----------------------------------------------------------------------------
module exyz_front
    import exyz_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_angles i_angles,
    input  logic    i_en,
    output logic    o_valid,
    output t_trig   o_trig
);

    localparam int LAT = CORDIC_STEPS + 2;
    logic [LAT-1:0] r_vld;

    // Track beats through the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    exyz_cordic u_cx (.i_clk, .i_en, .i_angle(i_angles.ax),
                      .o_sin(o_trig.sx), .o_cos(o_trig.cx));
    exyz_cordic u_cy (.i_clk, .i_en, .i_angle(i_angles.ay),
                      .o_sin(o_trig.sy), .o_cos(o_trig.cy));
    exyz_cordic u_cz (.i_clk, .i_en, .i_angle(i_angles.az),
                      .o_sin(o_trig.sz), .o_cos(o_trig.cz));

    assign o_valid = r_vld[LAT-1] & i_en;

endmodule

>>> sv/exyz_queue.sv
// ----------------------------------------------------------------------------
// exyz_queue: small FIFO between the trig front end and the matrix back end
// Flop-based ring with a fill count.
// ----------------------------------------------------------------------------
module exyz_queue
    import exyz_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_trig i_data,
    input  logic  i_pop,
    output logic  o_empty,
    output logic  o_full,
    output t_trig o_data
);

    t_trig          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));

endmodule

>>> sv/exyz_back.sv
// ----------------------------------------------------------------------------
// exyz_back: matrix back end
// Forms A = Rx*Ry, then R = A*Rz in two multiply stages plus an output stage.
// ----------------------------------------------------------------------------
module exyz_back
    import exyz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_trig       i_trig,
    output logic        o_ready,
    output logic        o_valid,
    output logic [143:0] o_data,
    input  logic        i_ready
);

    typedef logic signed [PW:0] t_wide;

    logic  en;
    logic  r_v1, r_v2, r_v3;
    t_coef r_a00, r_a02, r_a10, r_a11, r_a12, r_a20, r_a21, r_a22, r_sz, r_cz;
    t_wide r_p [10];
    t_coef r_a02b, r_a12b, r_a22b;
    logic [143:0] r_out;

    // Full-precision product of two coefficients, sign-extended to the sum width
    function automatic t_wide mul(input t_coef a, input t_coef b);
        logic signed [PW-1:0] p;
        begin
            p   = a * b;
            mul = t_wide'(p);
        end
    endfunction

    assign en      = !r_v3 || i_ready;
    assign o_ready = en;

    // Stage 1: products of x and y terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a00 <= i_trig.cy;
            r_a02 <= i_trig.sy;
            r_a10 <= round_prod(mul(i_trig.sx, i_trig.sy));
            r_a11 <= i_trig.cx;
            r_a12 <= round_prod(-mul(i_trig.sx, i_trig.cy));
            r_a20 <= round_prod(-mul(i_trig.cx, i_trig.sy));
            r_a21 <= i_trig.sx;
            r_a22 <= round_prod(mul(i_trig.cx, i_trig.cy));
            r_sz  <= i_trig.sz;
            r_cz  <= i_trig.cz;
        end
    end

    // Stage 2: products with z terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= mul(r_a00, r_cz);
            r_p[1] <= mul(r_a00, r_sz);
            r_p[2] <= mul(r_a10, r_cz);
            r_p[3] <= mul(r_a11, r_sz);
            r_p[4] <= mul(r_a10, r_sz);
            r_p[5] <= mul(r_a11, r_cz);
            r_p[6] <= mul(r_a20, r_cz);
            r_p[7] <= mul(r_a21, r_sz);
            r_p[8] <= mul(r_a20, r_sz);
            r_p[9] <= mul(r_a21, r_cz);
            r_a02b <= r_a02;
            r_a12b <= r_a12;
            r_a22b <= r_a22;
        end
    end

    // Stage 3: sum pairs, round and pack
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {
                OUT_BITS'(r_a22b),
                OUT_BITS'(round_prod(r_p[9] - r_p[8])),
                OUT_BITS'(round_prod(r_p[6] + r_p[7])),
                OUT_BITS'(r_a12b),
                OUT_BITS'(round_prod(r_p[5] - r_p[4])),
                OUT_BITS'(round_prod(r_p[2] + r_p[3])),
                OUT_BITS'(r_a02b),
                OUT_BITS'(round_prod(-r_p[1])),
                OUT_BITS'(round_prod(r_p[0]))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_out;

endmodule

>>> sv/euler_xyz_rotation_matrix.sv
// Throughput: one angle triple per cycle while the queue is not full; set by the
// 30-stage CORDIC pipes. The front pipe halts only when the queue could overflow;
// the back end stalls on its own on m_axis_tready.
// Reset (i_rst_n low, synchronous) clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix: angles to 3x3 rotation matrix R = Rx*Ry*Rz
// Front end computes sin/cos, queue decouples, back end forms the matrix.
// ----------------------------------------------------------------------------
module euler_xyz_rotation_matrix
    import exyz_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // angle_x, angle_y, angle_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // m00,m01,m02,m10,m11,m12,m20,m21,m22
);

    localparam int INFL = CORDIC_STEPS + 2;
    logic    front_en, front_vld, q_empty, q_full, back_rdy, pop;
    t_angles angles;
    t_trig   trig_f, trig_q;
    logic [5:0] r_infl;

    assign angles.ax = s_axis_tdata[15:0];
    assign angles.ay = s_axis_tdata[31:16];
    assign angles.az = s_axis_tdata[47:32];

    // The front pipe can hold more beats than the queue can absorb; with
    // the queue small, stall the whole front pipe while the queue is full
    assign front_en      = !q_full;
    assign s_axis_tready = front_en;
    assign pop           = !q_empty && back_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infl <= '0;
        end else begin
            r_infl <= r_infl + 6'(s_axis_tvalid && s_axis_tready) - 6'(pop);
        end
    end

    exyz_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .i_angles(angles),
        .i_en(front_en), .o_valid(front_vld), .o_trig(trig_f));

    exyz_queue u_queue (
        .i_clk, .i_rst_n, .i_push(front_vld), .i_data(trig_f), .i_pop(pop),
        .o_empty(q_empty), .o_full(q_full), .o_data(trig_q));

    exyz_back u_back (
        .i_clk, .i_rst_n, .i_valid(pop), .i_trig(trig_q), .o_ready(back_rdy),
        .o_valid(m_axis_tvalid), .o_data(m_axis_tdata), .i_ready(m_axis_tready));

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !front_vld) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty) else $error("queue underflow");
    a_infl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_infl <= 6'(INFL + QDEPTH + 4)) else $error("in-flight count too high");
`endif

endmodule

>>> test/euler_xyz_rotation_matrix_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix_test: self-checking bench for the XYZ rotation block
// Drives angle triples with random idling on both sides and compares each
// matrix beat against a bit-exact CORDIC and fixed-point matrix predictor.
// ----------------------------------------------------------------------------
module euler_xyz_rotation_matrix_test;

    localparam int N_RANDOM    = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 60;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;   // angle_x, angle_y, angle_z
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // m00,m01,m02,m10,m11,m12,m20,m21,m22

    typedef logic [143:0] t_matrix;

    // angle row; when known is set the matrix is typed in as well
    typedef struct {
        logic [15:0] ax, ay, az;
        bit          known;
        t_matrix     mat;
    } t_row;

    t_matrix     expected_mats[$];
    int          errors = 0;
    int          cycles = 0;
    bit          drain_phase = 0;
    bit          tx_idle_free = 0;

    euler_xyz_rotation_matrix uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // CORDIC arctangent steps, 2^-32 turn units
    function automatic longint atan_step(int i);
        longint tbl [30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
            20, 10, 5, 3, 1};
        return tbl[i];
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // rounding product helper: add half lsb, floor shift by 14, clamp
    function automatic longint round14(longint p);
        return clamp_one((p + 8192) >>> 14);
    endfunction

    function automatic void trig_of(logic [15:0] raw, output longint s, output longint c);
        logic [31:0] phase;
        bit          flip;
        longint      x, y, z, dx, dy;
        phase = {raw, 16'h0};
        flip  = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip) phase = phase - 32'h8000_0000;
        z = longint'($signed(phase));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = clamp_one((x + (1 <<< 15)) >>> 16);
        s = clamp_one((y + (1 <<< 15)) >>> 16);
    endfunction

    function automatic t_matrix rotation_of(logic [15:0] ax, logic [15:0] ay,
                                            logic [15:0] az);
        longint sx, cx, sy, cy, sz, cz;
        longint a10, a12, a20, a22;
        longint e [9];
        t_matrix m;
        trig_of(ax, sx, cx);
        trig_of(ay, sy, cy);
        trig_of(az, sz, cz);
        a10 = round14(sx * sy);
        a12 = round14(-sx * cy);
        a20 = round14(-cx * sy);
        a22 = round14(cx * cy);
        e[0] = round14(cy * cz);
        e[1] = round14(-cy * sz);
        e[2] = sy;
        e[3] = round14(a10 * cz + cx * sz);
        e[4] = round14(-a10 * sz + cx * cz);
        e[5] = a12;
        e[6] = round14(a20 * cz + sx * sz);
        e[7] = round14(-a20 * sz + sx * cz);
        e[8] = a22;
        for (int k = 0; k < 9; k++) m[16*k +: 16] = e[k][15:0];
        return m;
    endfunction

    // directed rows: the zero row has an exact, readable matrix typed in
    t_row directed [] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1, {16'h4000, 16'h0000, 16'h0000,
                                            16'h0000, 16'h4000, 16'h0000,
                                            16'h0000, 16'h0000, 16'h4000}},
        '{16'h8000, 16'h8000, 16'h8000, 0, '0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0},
        '{16'h4000, 16'h0000, 16'h0000, 0, '0},
        '{16'h0000, 16'h4000, 16'h0000, 0, '0},
        '{16'h0000, 16'h0000, 16'h4000, 0, '0},
        '{16'hC000, 16'hC000, 16'hC000, 0, '0},
        '{16'h2000, 16'h2000, 16'h2000, 0, '0},
        '{16'hE000, 16'h6000, 16'hA000, 0, '0},
        '{16'h3FFF, 16'h4001, 16'hBFFF, 0, '0},
        '{16'h0001, 16'hFFFF, 16'h8001, 0, '0},
        '{16'h5555, 16'hAAAA, 16'hFFFF, 0, '0},
        '{16'h8000, 16'h0000, 16'h7FFF, 0, '0},
        '{16'hFFFF, 16'h8000, 16'h0001, 0, '0}
    };

    // send one angle beat after an optional random gap, holding valid until accepted
    task automatic send_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               t_matrix mat);
        if (!tx_idle_free && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {az, ay, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_mats.push_back(mat);
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [15:0] ax, ay, az;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed[r])
            send_angles(directed[r].ax, directed[r].ay, directed[r].az,
                        directed[r].known ? directed[r].mat
                            : rotation_of(directed[r].ax, directed[r].ay, directed[r].az));
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 150) tx_idle_free = 1;
            ax = $urandom; ay = $urandom; az = $urandom;
            send_angles(ax, ay, az, rotation_of(ax, ay, az));
        end
        s_axis_tvalid <= 1'b0;
        drain_phase = 1;
        while (expected_mats.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0)
            $display("euler_xyz_rotation_matrix_test: PASS");
        else
            $display("euler_xyz_rotation_matrix_test: FAIL");
        $finish;
    end

    // result-side backpressure in bursts, none near the end
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!tx_idle_free && !drain_phase && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // check each result beat against the oldest expected matrix
    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_mats.size() == 0) begin
                $display("%0t: unexpected matrix beat %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = expected_mats.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_axis_tdata[16*k +: 16] !== want[16*k +: 16]) begin
                        $display("%0t: entry m%0d%0d expected %0d actual %0d", $time,
                                 k / 3, k % 3, $signed(want[16*k +: 16]),
                                 $signed(m_axis_tdata[16*k +: 16]));
                        errors++;
                    end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("euler_xyz_rotation_matrix_test: FAIL");
            $finish;
        end
    end

endmodule
